@@ hw/rtl/cmt_pkg.sv @@
// Shared types, constants and helper functions of the calorimeter muon trigger.
// Used by the controller, the datapath, the top level and the port checker.
package cmt_pkg;

  localparam int NUM_SECTORS     = 16;
  localparam int MODS_PER_SECTOR = 12;
  localparam int NUM_OCTANTS     = 8;
  localparam int THR_DEPTH       = NUM_SECTORS * MODS_PER_SECTOR;
  localparam int THR_AW          = $clog2(THR_DEPTH);
  localparam int SEC_IDX_W       = $clog2(NUM_SECTORS);

  localparam int THR_W  = 7;
  localparam int ADC_W  = 7;
  localparam int SEC_W  = 4;
  localparam int MOD_W  = 4;
  localparam int CFG_W  = 4;
  localparam int CIDX_W = 2;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [CIDX_W-1:0] {
    REG_TOWERS_NEEDED = 2'd0,
    REG_CHANNEL_LIMIT = 2'd1,
    REG_MUON_NEEDED   = 2'd2,
    REG_QUIET_NEEDED  = 2'd3
  } cfg_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic check;
    logic eval;
    logic load;
  } ctl_cmd_t;

  // Status of the transaction held in the datapath.
  typedef struct packed {
    logic is_sample;
    logic is_last;
  } dp_status_t;

  // Noise thresholds that the table holds until an entry is written.
  localparam logic [THR_W-1:0] DEFAULT_THR [16][12] = '{
    '{7'd11, 7'd10, 7'd14, 7'd11, 7'd11, 7'd12, 7'd11, 7'd10, 7'd19, 7'd30, 7'd11, 7'd10},
    '{7'd11, 7'd11, 7'd13, 7'd11, 7'd12, 7'd18, 7'd12, 7'd10, 7'd11, 7'd11, 7'd11, 7'd10},
    '{7'd11, 7'd14, 7'd11, 7'd11, 7'd11, 7'd13, 7'd23, 7'd11, 7'd11, 7'd11, 7'd10, 7'd10},
    '{7'd12, 7'd14, 7'd10, 7'd10, 7'd21, 7'd10, 7'd11, 7'd10, 7'd11, 7'd11, 7'd10, 7'd11},
    '{7'd10, 7'd12, 7'd14, 7'd19, 7'd11, 7'd10, 7'd11, 7'd12, 7'd12, 7'd11, 7'd10, 7'd10},
    '{7'd10, 7'd11, 7'd11, 7'd10, 7'd11, 7'd14, 7'd11, 7'd11, 7'd11, 7'd10, 7'd11, 7'd11},
    '{7'd10, 7'd11, 7'd11, 7'd11, 7'd12, 7'd11, 7'd11, 7'd18, 7'd10, 7'd11, 7'd11, 7'd10},
    '{7'd10, 7'd11, 7'd10, 7'd11, 7'd11, 7'd11, 7'd12, 7'd11, 7'd11, 7'd11, 7'd10, 7'd10},
    '{7'd10, 7'd11, 7'd11, 7'd11, 7'd11, 7'd14, 7'd11, 7'd11, 7'd18, 7'd10, 7'd11, 7'd11},
    '{7'd10, 7'd11, 7'd11, 7'd10, 7'd10, 7'd11, 7'd10, 7'd11, 7'd11, 7'd11, 7'd10, 7'd23},
    '{7'd10, 7'd11, 7'd10, 7'd10, 7'd10, 7'd13, 7'd10, 7'd10, 7'd10, 7'd11, 7'd10, 7'd12},
    '{7'd10, 7'd11, 7'd10, 7'd12, 7'd10, 7'd10, 7'd11, 7'd11, 7'd10, 7'd10, 7'd11, 7'd11},
    '{7'd11, 7'd13, 7'd12, 7'd13, 7'd12, 7'd11, 7'd11, 7'd10, 7'd10, 7'd10, 7'd20, 7'd11},
    '{7'd11, 7'd10, 7'd11, 7'd10, 7'd10, 7'd26, 7'd10, 7'd11, 7'd12, 7'd10, 7'd11, 7'd11},
    '{7'd12, 7'd11, 7'd11, 7'd12, 7'd10, 7'd11, 7'd10, 7'd11, 7'd10, 7'd10, 7'd15, 7'd11},
    '{7'd10, 7'd11, 7'd11, 7'd10, 7'd11, 7'd10, 7'd11, 7'd11, 7'd11, 7'd12, 7'd10, 7'd10}
  };

  // Tower of a module: three modules to a tower.
  function automatic logic [1:0] tower_of(input logic [MOD_W-1:0] m);
    logic [1:0] t;
    if (m < MOD_W'(3)) begin
      t = 2'd0;
    end else if (m < MOD_W'(6)) begin
      t = 2'd1;
    end else if (m < MOD_W'(9)) begin
      t = 2'd2;
    end else begin
      t = 2'd3;
    end
    return t;
  endfunction

  function automatic logic [2:0] popcount4(input logic [3:0] v);
    logic [2:0] n;
    n = '0;
    for (int i = 0; i < 4; i++) begin
      n = n + 3'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

endpackage

@@ hw/rtl/calorimeter_muon_trigger.sv @@
// Top level of the calorimeter muon trigger: joins the controller and the datapath.
// Depends on cmt_pkg, cmt_ctrl, cmt_datapath and cmt_ram.

// The block takes one transaction at a time. A threshold write and a channel sample
// each pass through a check state, which covers the registered read of the threshold
// RAM; a sample marked last then also passes through octant evaluation and decision,
// where it waits while the previous result is still held by out_stall. The table
// comes out of reset holding the default noise thresholds at once, through one written
// bit per entry, so no clearing pass follows reset. Sector counters are cleared at
// every octant evaluation.
module calorimeter_muon_trigger
  import cmt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CIDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   cmd,
  input  logic [SEC_W-1:0]       sector,
  input  logic [MOD_W-1:0]       module_req,
  input  logic [ADC_W-1:0]       adc_value,
  input  logic                   last,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [NUM_OCTANTS-1:0] muon_octants,
  output logic [NUM_OCTANTS-1:0] quiet_octants,
  output logic                   muon_decision
);

  ctl_cmd_t   ctl;
  dp_status_t status;

  cmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .ctl      (ctl)
  );

  cmt_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sector       (sector),
    .module_req   (module_req),
    .adc_value    (adc_value),
    .last         (last),
    .muon_octants (muon_octants),
    .quiet_octants(quiet_octants),
    .muon_decision(muon_decision)
  );

endmodule

@@ hw/rtl/cmt_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing else in the project.
module cmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/cmt_ctrl.sv @@
// Controller of the calorimeter muon trigger: sequences one transaction at a time.
// Depends on cmt_pkg for the command and status structs.
module cmt_ctrl
  import cmt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output ctl_cmd_t   ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_EVAL,
    S_DECIDE
  } state_t;

  state_t state;

  always_comb begin
    ctl.accept = in_valid && !in_stall;
    ctl.check  = (state == S_CHECK);
    ctl.eval   = (state == S_EVAL);
    ctl.load   = (state == S_DECIDE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state    <= S_CHECK;
            in_stall <= 1'b1;
          end
        end
        S_CHECK: begin
          if (status.is_sample && status.is_last) begin
            state <= S_EVAL;
          end else begin
            state    <= S_IDLE;
            in_stall <= 1'b0;
          end
        end
        S_EVAL: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (ctl.load) begin
            state    <= S_IDLE;
            in_stall <= 1'b0;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_stall <= 1'b0;
        end
      endcase

      if (ctl.load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/cmt_datapath.sv @@
// Datapath of the calorimeter muon trigger: threshold table, sector state,
// octant evaluation and the result register. Depends on cmt_pkg and cmt_ram.
module cmt_datapath
  import cmt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  ctl_cmd_t                 ctl,
  output dp_status_t               status,
  input  logic                     cfg_write,
  input  logic [CIDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     cmd,
  input  logic [SEC_W-1:0]         sector,
  input  logic [MOD_W-1:0]         module_req,
  input  logic [ADC_W-1:0]         adc_value,
  input  logic                     last,
  output logic [NUM_OCTANTS-1:0]   muon_octants,
  output logic [NUM_OCTANTS-1:0]   quiet_octants,
  output logic                     muon_decision
);

  // Configuration registers.
  logic [2:0] towers_needed;
  logic [3:0] channel_limit;
  logic [3:0] muon_needed;
  logic [3:0] quiet_needed;

  // Transaction held while it is being worked on.
  logic             cmd_q;
  logic             last_q;
  logic [SEC_W-1:0] sec_q;
  logic [MOD_W-1:0] mod_q;
  logic [ADC_W-1:0] adc_q;
  logic             addr_ok_q;
  logic             written_q;
  logic [THR_W-1:0] def_q;

  logic                 addr_ok;
  logic [THR_AW-1:0]    thr_addr;
  logic                 thr_we;
  logic [THR_W-1:0]     thr_rdata;
  logic [THR_W-1:0]     thr;
  logic [THR_DEPTH-1:0] thr_written;
  logic                 hit;
  logic [SEC_IDX_W-1:0] sec_idx;
  logic [1:0]           tower;

  logic [3:0] tower_flags [NUM_SECTORS];
  logic [3:0] hit_count   [NUM_SECTORS];

  logic [NUM_OCTANTS-1:0] muon_mask;
  logic [NUM_OCTANTS-1:0] quiet_mask;
  logic [NUM_OCTANTS-1:0] muon_mask_next;
  logic [NUM_OCTANTS-1:0] quiet_mask_next;

  assign addr_ok  = (int'(sector) < NUM_SECTORS) && (int'(module_req) < MODS_PER_SECTOR);
  assign thr_addr = THR_AW'(int'(sector) * MODS_PER_SECTOR + int'(module_req));
  assign thr_we   = ctl.accept && (cmd == CMD_WRITE) && addr_ok;

  cmt_ram #(
    .WIDTH(THR_W),
    .DEPTH(THR_DEPTH)
  ) u_thr_ram (
    .clk  (clk),
    .we   (thr_we),
    .waddr(thr_addr),
    .wdata(adc_value),
    .raddr(thr_addr),
    .rdata(thr_rdata)
  );

  assign status.is_sample = (cmd_q == CMD_SAMPLE);
  assign status.is_last   = last_q;

  // Entries never written read as their default threshold.
  assign thr     = written_q ? thr_rdata : def_q;
  assign hit     = (cmd_q == CMD_SAMPLE) && addr_ok_q && (adc_q > thr);
  assign sec_idx = SEC_IDX_W'(sec_q);
  assign tower   = tower_of(mod_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      towers_needed <= 3'd3;
      channel_limit <= 4'd3;
      muon_needed   <= 4'd1;
      quiet_needed  <= 4'd7;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_TOWERS_NEEDED: towers_needed <= cfg_data[2:0];
        REG_CHANNEL_LIMIT: channel_limit <= cfg_data;
        REG_MUON_NEEDED:   muon_needed   <= cfg_data;
        REG_QUIET_NEEDED:  quiet_needed  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_written <= '0;
    end else if (thr_we) begin
      thr_written[thr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_q     <= cmd;
      last_q    <= last;
      sec_q     <= sector;
      mod_q     <= module_req;
      adc_q     <= adc_value;
      addr_ok_q <= addr_ok;
      written_q <= thr_written[thr_addr];
      def_q     <= DEFAULT_THR[sector][module_req];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SECTORS; s++) begin
        tower_flags[s] <= '0;
        hit_count[s]   <= '0;
      end
    end else if (ctl.eval) begin
      for (int s = 0; s < NUM_SECTORS; s++) begin
        tower_flags[s] <= '0;
        hit_count[s]   <= '0;
      end
    end else if (ctl.check && hit) begin
      tower_flags[sec_idx] <= tower_flags[sec_idx] | (4'b0001 << tower);
      if (hit_count[sec_idx] != 4'hF) begin
        hit_count[sec_idx] <= hit_count[sec_idx] + 4'd1;
      end
    end
  end

  // Two sectors share an octant; sectors past the last octant are dropped.
  always_comb begin
    muon_mask_next  = '0;
    quiet_mask_next = '1;
    for (int s = 0; s < NUM_SECTORS; s++) begin
      if ((s >> 1) < NUM_OCTANTS) begin
        if (popcount4(tower_flags[s]) >= towers_needed) begin
          muon_mask_next[3'(s >> 1)] = 1'b1;
        end
        if (hit_count[s] > channel_limit) begin
          quiet_mask_next[3'(s >> 1)] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      muon_mask  <= muon_mask_next;
      quiet_mask <= quiet_mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      muon_octants  <= muon_mask;
      quiet_octants <= quiet_mask;
      muon_decision <= (popcount8(muon_mask) >= muon_needed) &&
                       (popcount8(quiet_mask) >= quiet_needed);
    end
  end

endmodule

@@ hw/rtl/cmt_checker.sv @@
// Port-level checker of the calorimeter muon trigger, bound to the top level.
// Depends on cmt_pkg for field widths and command codes.
module cmt_port_checker
  import cmt_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   cmd,
  input logic                   last,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [NUM_OCTANTS-1:0] muon_octants,
  input logic [NUM_OCTANTS-1:0] quiet_octants,
  input logic                   muon_decision
);

  // A result held back by the receiver stays offered unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(muon_octants) &&
      $stable(quiet_octants) && $stable(muon_decision))
    else $error("stalled result dropped or changed");

  // The block is ready again right after reset and holds no result.
  assert property (@(posedge clk) rst |=> !in_stall && !out_valid)
    else $error("block not idle after reset");

  // Every accepted transaction occupies the block, so no two are accepted back to back.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("transaction accepted on back-to-back cycles");

  // Only a channel sample marked last produces a result.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid && !(cmd == CMD_SAMPLE && last)
      |=> !out_valid ##1 !out_valid)
    else $error("result produced without a last channel sample");

endmodule

bind calorimeter_muon_trigger cmt_port_checker u_cmt_port_checker (.*);

@@ verif/cmt_checker.sv @@
`timescale 1ns / 100ps
// cmt_checker: watches the ports of calorimeter_muon_trigger, predicts each trigger
// result and compares it with what the block emits. Depends on cmt_pkg.
module cmt_checker
  import cmt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CIDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic                   cmd,
  input  logic [SEC_W-1:0]       sector,
  input  logic [MOD_W-1:0]       module_req,
  input  logic [ADC_W-1:0]       adc_value,
  input  logic                   last,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [NUM_OCTANTS-1:0] muon_octants,
  input  logic [NUM_OCTANTS-1:0] quiet_octants,
  input  logic                   muon_decision,
  output int                     errors,
  output int                     pending
);

  typedef struct packed {
    logic [NUM_OCTANTS-1:0] muon;
    logic [NUM_OCTANTS-1:0] quiet;
    logic                   decision;
  } trig_word_t;

  // Noise levels the threshold table holds until an entry is overwritten.
  localparam logic [THR_W-1:0] NOISE_FLOOR [16][12] = '{
    '{7'd11, 7'd10, 7'd14, 7'd11, 7'd11, 7'd12, 7'd11, 7'd10, 7'd19, 7'd30, 7'd11, 7'd10},
    '{7'd11, 7'd11, 7'd13, 7'd11, 7'd12, 7'd18, 7'd12, 7'd10, 7'd11, 7'd11, 7'd11, 7'd10},
    '{7'd11, 7'd14, 7'd11, 7'd11, 7'd11, 7'd13, 7'd23, 7'd11, 7'd11, 7'd11, 7'd10, 7'd10},
    '{7'd12, 7'd14, 7'd10, 7'd10, 7'd21, 7'd10, 7'd11, 7'd10, 7'd11, 7'd11, 7'd10, 7'd11},
    '{7'd10, 7'd12, 7'd14, 7'd19, 7'd11, 7'd10, 7'd11, 7'd12, 7'd12, 7'd11, 7'd10, 7'd10},
    '{7'd10, 7'd11, 7'd11, 7'd10, 7'd11, 7'd14, 7'd11, 7'd11, 7'd11, 7'd10, 7'd11, 7'd11},
    '{7'd10, 7'd11, 7'd11, 7'd11, 7'd12, 7'd11, 7'd11, 7'd18, 7'd10, 7'd11, 7'd11, 7'd10},
    '{7'd10, 7'd11, 7'd10, 7'd11, 7'd11, 7'd11, 7'd12, 7'd11, 7'd11, 7'd11, 7'd10, 7'd10},
    '{7'd10, 7'd11, 7'd11, 7'd11, 7'd11, 7'd14, 7'd11, 7'd11, 7'd18, 7'd10, 7'd11, 7'd11},
    '{7'd10, 7'd11, 7'd11, 7'd10, 7'd10, 7'd11, 7'd10, 7'd11, 7'd11, 7'd11, 7'd10, 7'd23},
    '{7'd10, 7'd11, 7'd10, 7'd10, 7'd10, 7'd13, 7'd10, 7'd10, 7'd10, 7'd11, 7'd10, 7'd12},
    '{7'd10, 7'd11, 7'd10, 7'd12, 7'd10, 7'd10, 7'd11, 7'd11, 7'd10, 7'd10, 7'd11, 7'd11},
    '{7'd11, 7'd13, 7'd12, 7'd13, 7'd12, 7'd11, 7'd11, 7'd10, 7'd10, 7'd10, 7'd20, 7'd11},
    '{7'd11, 7'd10, 7'd11, 7'd10, 7'd10, 7'd26, 7'd10, 7'd11, 7'd12, 7'd10, 7'd11, 7'd11},
    '{7'd12, 7'd11, 7'd11, 7'd12, 7'd10, 7'd11, 7'd10, 7'd11, 7'd10, 7'd10, 7'd15, 7'd11},
    '{7'd10, 7'd11, 7'd11, 7'd10, 7'd11, 7'd10, 7'd11, 7'd11, 7'd11, 7'd12, 7'd10, 7'd10}
  };

  logic [THR_W-1:0] noise_thr [NUM_SECTORS][MODS_PER_SECTOR];
  logic [3:0]       towers_hit [NUM_SECTORS];
  logic [3:0]       hits_seen [NUM_SECTORS];
  logic [2:0]       towers_needed;
  logic [3:0]       channel_limit;
  logic [3:0]       muon_needed;
  logic [3:0]       quiet_needed;
  trig_word_t       trig_q [$];

  task automatic report(input string what, input int got, input int want);
    $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  // Octant masks and decision from the sector counters as they stand.
  function automatic trig_word_t evaluate_sample();
    trig_word_t w;
    int         oct;
    w.muon  = '0;
    w.quiet = '1;
    for (int s = 0; s < NUM_SECTORS; s++) begin
      oct = s / 2;
      if (oct < NUM_OCTANTS) begin
        if ($countones(towers_hit[s]) >= towers_needed) begin
          w.muon[oct] = 1'b1;
        end
        if (hits_seen[s] > channel_limit) begin
          w.quiet[oct] = 1'b0;
        end
      end
    end
    w.decision = ($countones(w.muon) >= muon_needed) && ($countones(w.quiet) >= quiet_needed);
    return w;
  endfunction

  task automatic take_transaction();
    logic in_range;
    in_range = (sector < NUM_SECTORS) && (module_req < MODS_PER_SECTOR);
    if (cmd == CMD_WRITE) begin
      if (in_range) begin
        noise_thr[sector][module_req] = adc_value;
      end
    end else begin
      if (in_range && adc_value > noise_thr[sector][module_req]) begin
        towers_hit[sector][module_req / 3] = 1'b1;
        if (hits_seen[sector] != 4'd15) begin
          hits_seen[sector]++;
        end
      end
      if (last) begin
        trig_q = {trig_q, evaluate_sample()};
        for (int s = 0; s < NUM_SECTORS; s++) begin
          towers_hit[s] = '0;
          hits_seen[s]  = '0;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    trig_word_t want;
    if (rst) begin
      for (int s = 0; s < NUM_SECTORS; s++) begin
        for (int m = 0; m < MODS_PER_SECTOR; m++) begin
          noise_thr[s][m] = NOISE_FLOOR[s % 16][m % 12];
        end
        towers_hit[s] = '0;
        hits_seen[s]  = '0;
      end
      towers_needed = 3'd3;
      channel_limit = 4'd3;
      muon_needed   = 4'd1;
      quiet_needed  = 4'd7;
      trig_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_TOWERS_NEEDED: towers_needed = cfg_data[2:0];
          REG_CHANNEL_LIMIT: channel_limit = cfg_data;
          REG_MUON_NEEDED:   muon_needed   = cfg_data;
          REG_QUIET_NEEDED:  quiet_needed  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        take_transaction();
      end
      if (out_valid && !out_stall) begin
        if (trig_q.size() == 0) begin
          report("unexpected trigger result", 1, 0);
        end else begin
          want = trig_q.pop_front();
          if (muon_octants !== want.muon) begin
            report("muon_octants", muon_octants, want.muon);
          end
          if (quiet_octants !== want.quiet) begin
            report("quiet_octants", quiet_octants, want.quiet);
          end
          if (muon_decision !== want.decision) begin
            report("muon_decision", muon_decision, want.decision);
          end
        end
      end
    end
    pending <= trig_q.size();
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for calorimeter_muon_trigger.
// Depends on cmt_pkg, the block's RTL and cmt_checker.
module tb_top;
  import cmt_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int DRAIN_CYCLES = 10;
  localparam int STALL_LIMIT  = 3000;
  localparam int BLOCK_ITEMS  = 50;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CIDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   cmd = CMD_SAMPLE;
  logic [SEC_W-1:0]       sector = '0;
  logic [MOD_W-1:0]       module_req = '0;
  logic [ADC_W-1:0]       adc_value = '0;
  logic                   last = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [NUM_OCTANTS-1:0] muon_octants;
  logic [NUM_OCTANTS-1:0] quiet_octants;
  logic                   muon_decision;

  int errors;
  int pending;
  int gap_pct   = 9;
  int stall_pct = 85;
  int n_sent    = 0;
  int idle_run  = 0;

  calorimeter_muon_trigger u_top (.*);

  cmt_checker u_chk (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // Ends the run when no transaction of any kind moves for too long.
  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
    end
    if (idle_run >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic drive_item(input logic c, input logic [SEC_W-1:0] s,
                            input logic [MOD_W-1:0] m, input logic [ADC_W-1:0] a,
                            input logic l);
    cmd        <= c;
    sector     <= s;
    module_req <= m;
    adc_value  <= a;
    last       <= l;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    // Each idle cycle is drawn on its own, so gap_pct is the chance that another idle cycle follows.
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Lets every outstanding result drain, then idles so a trailing write can finish.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [3:0] tn, input logic [3:0] cl,
                              input logic [3:0] mn, input logic [3:0] qn);
    settle();
    write_reg(REG_TOWERS_NEEDED, tn);
    write_reg(REG_CHANNEL_LIMIT, cl);
    write_reg(REG_MUON_NEEDED, mn);
    write_reg(REG_QUIET_NEEDED, qn);
    cfg_write <= 1'b0;
  endtask

  // Modules 12 to 15 are outside the trigger and must be ignored.
  function automatic logic [MOD_W-1:0] pick_module();
    if ($urandom_range(99) < 12) begin
      return MOD_W'($urandom_range(12, 15));
    end
    return MOD_W'($urandom_range(0, 11));
  endfunction

  // Mostly values near the noise thresholds, so hits and misses both occur.
  function automatic logic [ADC_W-1:0] pick_level();
    int r;
    r = $urandom_range(99);
    if (r < 5) begin
      return '0;
    end else if (r < 10) begin
      return '1;
    end else if (r < 80) begin
      return ADC_W'($urandom_range(5, 35));
    end
    return ADC_W'($urandom_range(0, 127));
  endfunction

  // One time sample: channels concentrated on a few sectors, closed by last.
  task automatic run_frame();
    int               n;
    int               kind;
    logic [SEC_W-1:0] hot [3];
    logic [SEC_W-1:0] s;
    kind = $urandom_range(99);
    if (kind < 6) begin
      // Flood one sector, enough hits to push the channel count to saturation.
      s = SEC_W'($urandom_range(0, 15));
      n = $urandom_range(16, 20);
      for (int i = 0; i < n; i++) begin
        drive_item(CMD_SAMPLE, s, MOD_W'($urandom_range(0, 11)), '1, i == n - 1);
      end
    end else begin
      n = (kind < 15) ? 1 : $urandom_range(2, 24);
      for (int h = 0; h < 3; h++) begin
        hot[h] = SEC_W'($urandom_range(0, 15));
      end
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 8) begin
          drive_item(CMD_WRITE, SEC_W'($urandom_range(0, 15)), pick_module(), pick_level(),
                     1'($urandom_range(0, 1)));
        end
        s = ($urandom_range(99) < 75) ? hot[$urandom_range(0, 2)]
                                      : SEC_W'($urandom_range(0, 15));
        drive_item(CMD_SAMPLE, s, pick_module(), pick_level(), i == n - 1);
      end
    end
  endtask

  initial begin
    int         base;
    logic [3:0] tn;
    logic [3:0] cl;
    logic [3:0] mn;
    logic [3:0] qn;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part, run at the reset register values.
    drive_item(CMD_WRITE, 4'd0, 4'd0, 7'd0, 1'b1);     // last on a write gives nothing
    drive_item(CMD_WRITE, 4'd7, 4'd13, 7'd0, 1'b0);    // write to an ignored module
    drive_item(CMD_SAMPLE, 4'd0, 4'd0, 7'd1, 1'b0);
    drive_item(CMD_SAMPLE, 4'd0, 4'd4, 7'd127, 1'b0);
    drive_item(CMD_SAMPLE, 4'd0, 4'd8, 7'd127, 1'b0);
    drive_item(CMD_SAMPLE, 4'd0, 4'd11, 7'd127, 1'b0);
    drive_item(CMD_SAMPLE, 4'd7, 4'd13, 7'd127, 1'b0);
    drive_item(CMD_SAMPLE, 4'd15, 4'd15, 7'd127, 1'b0);
    drive_item(CMD_SAMPLE, 4'd15, 4'd0, 7'd0, 1'b1);
    drive_item(CMD_SAMPLE, 4'd9, 4'd5, 7'd0, 1'b1);    // nothing hit at all
    drive_item(CMD_WRITE, 4'd2, 4'd5, 7'd127, 1'b0);
    drive_item(CMD_SAMPLE, 4'd2, 4'd5, 7'd127, 1'b0);  // equal to threshold is no hit
    drive_item(CMD_WRITE, 4'd2, 4'd5, 7'd126, 1'b1);
    drive_item(CMD_SAMPLE, 4'd2, 4'd5, 7'd127, 1'b0);
    drive_item(CMD_SAMPLE, 4'd2, 4'd5, 7'd127, 1'b0);  // same channel counted again
    drive_item(CMD_SAMPLE, 4'd2, 4'd0, 7'd127, 1'b0);
    drive_item(CMD_SAMPLE, 4'd2, 4'd9, 7'd127, 1'b0);
    drive_item(CMD_SAMPLE, 4'd14, 4'd2, 7'd127, 1'b0);
    drive_item(CMD_SAMPLE, 4'd15, 4'd11, 7'd127, 1'b1);

    for (int blk = 0; blk < 15; blk++) begin
      if (blk < 5) begin
        gap_pct   = 9;
        stall_pct = 85;
      end else if (blk < 10) begin
        gap_pct   = 85;
        stall_pct = 9;
      end else begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      case (blk)
        0: program_regs(4'd1, 4'd0, 4'd1, 4'd0);
        1: program_regs(4'd4, 4'd12, 4'd8, 4'd8);
        default: begin
          tn = ($urandom_range(99) < 10) ? 4'($urandom_range(0, 7)) : 4'($urandom_range(1, 4));
          cl = ($urandom_range(99) < 10) ? 4'($urandom_range(13, 15))
                                         : 4'($urandom_range(0, 12));
          mn = ($urandom_range(99) < 10) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
          qn = ($urandom_range(99) < 10) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
          program_regs(tn, cl, mn, qn);
        end
      endcase
      base = n_sent;
      while (n_sent - base < BLOCK_ITEMS) run_frame();
    end

    settle();
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
